[hw/rtl/bm33_pkg.sv]
// Shared types, constants and helper functions for the 3x3 binary morphology stream.
// Used by bm33_ram, bm33_pass and binary_morphology_3x3_stream; depends on nothing else.
`default_nettype none
package bm33_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_WIDTH_DEFAULT   = 1024;
   localparam int MAX_HEIGHT_DEFAULT  = 1024;
   localparam int PASS_STAGES_DEFAULT = 4;

   // Frame size after reset and the smallest frame size accepted.
   localparam int DEFAULT_WIDTH  = 640;
   localparam int DEFAULT_HEIGHT = 480;
   localparam int MIN_DIM        = 3;

   // Each pass keeps two buffered rows per column.
   localparam int LINE_ROWS = 2;

   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 11;

   // Window bit groups: bits [2:0] are the left column, [8:6] the right column,
   // and within each column bit 0 is the top row and bit 2 the bottom row.
   localparam logic [8:0] WINDOW_FULL     = 9'h1FF;
   localparam logic [8:0] MASK_LEFT_COL   = 9'h007;
   localparam logic [8:0] MASK_RIGHT_COL  = 9'h1C0;
   localparam logic [8:0] MASK_TOP_ROW    = 9'h049;
   localparam logic [8:0] MASK_BOTTOM_ROW = 9'h124;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OPERATION_MODE = CSR_INDEX_WIDTH'(0),
      CSR_ELEMENT_SIZE   = CSR_INDEX_WIDTH'(1),
      CSR_IMAGE_WIDTH    = CSR_INDEX_WIDTH'(2),
      CSR_IMAGE_HEIGHT   = CSR_INDEX_WIDTH'(3)
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_ERODE  = 2'd0,
      MODE_DILATE = 2'd1,
      MODE_OPEN   = 2'd2,
      MODE_CLOSE  = 2'd3
   } mode_type;

   typedef enum logic {
      ACTION_PUSH  = 1'b0,
      ACTION_DRAIN = 1'b1
   } action_type;

   typedef struct packed {
      logic action;
      logic pixel_in;
   } req_type;

   typedef struct packed {
      logic pixel_out;
      logic frame_last;
   } rsp_type;

   // What travels between passes: a pixel with its value, or a drain step.
   typedef struct packed {
      logic is_pixel;
      logic value;
   } token_type;

   typedef struct packed {
      logic active;
      logic dilate;
   } pass_mode_type;

   typedef struct packed {
      pass_mode_type mode;
      logic          process;
      logic          restart;
      logic          clear;
   } pass_ctrl_type;

   // Role of one pass in the cascade for the current mode and element size.
   function automatic pass_mode_type pass_mode(mode_type mode, logic size, int stage,
                                               int stages);
      logic [2:0]    full;
      logic [2:0]    half;
      logic [2:0]    used;
      pass_mode_type pm;
      full = size ? 3'd2 : 3'd1;
      if (mode == MODE_OPEN || mode == MODE_CLOSE) begin
         full = full << 1;
      end
      half = full >> 1;
      used = (int'(full) > stages) ? 3'(stages) : full;
      pm.active = stage < int'(used);
      case (mode)
         MODE_ERODE:  pm.dilate = 1'b0;
         MODE_DILATE: pm.dilate = 1'b1;
         MODE_OPEN:   pm.dilate = stage >= int'(half);
         MODE_CLOSE:  pm.dilate = stage < int'(half);
         default:     pm.dilate = 1'b0;
      endcase
      return pm;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/bm33_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Depends on bm33_pkg for its default sizes only.
`default_nettype none
module bm33_ram #(
   parameter int WIDTH = bm33_pkg::LINE_ROWS,
   parameter int DEPTH = bm33_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/bm33_pass.sv]
// One streaming 3x3 erosion or dilation pass: raster position, fill count, window,
// and a two-row line store in bm33_ram. Depends on bm33_pkg and bm33_ram.
`default_nettype none
module bm33_pass #(
   parameter int MAX_WIDTH  = bm33_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bm33_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bm33_pkg::pass_ctrl_type           ctrl,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    width,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]      clear_addr,
   input  wire bm33_pkg::token_type               tok_in,
   output bm33_pkg::token_type                    tok_out,
   output logic                                   keep
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int FW = $clog2(MAX_WIDTH + 2);
   localparam int LR = bm33_pkg::LINE_ROWS;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [8:0]    win_ff, win_in;
   logic          fwd_hit_ff, fwd_hit_in;
   logic [LR-1:0] fwd_data_ff;

   logic          ram_we;
   logic [CW-1:0] ram_waddr;
   logic [LR-1:0] ram_wdata;
   logic [LR-1:0] ram_rdata;
   logic [LR-1:0] line;

   logic          pad;
   logic          advance;
   logic          borrow;
   logic          fill_short;
   logic [CW-1:0] w_last;
   logic [RW-1:0] h_last;
   logic [CW-1:0] qc;
   logic [HW:0]   row_ext;
   logic [HW:0]   row_sub;
   logic [HW:0]   qr_wide;
   logic [RW-1:0] qr;
   logic          q_last;
   logic [8:0]    win_new;
   logic [8:0]    mask;
   logic [8:0]    eff;
   logic          result;
   logic [CW-1:0] col_next;
   logic [RW-1:0] row_next;

   bm33_ram #(
      .WIDTH (LR),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (col_in),
      .rd_data (ram_rdata)
   );

   // A write and a read of the same column in one cycle returns the written data next cycle.
   assign line = fwd_hit_ff ? fwd_data_ff : ram_rdata;

   assign pad        = tok_in.is_pixel ? tok_in.value : 1'b0;
   assign advance    = ctrl.mode.active && (tok_in.is_pixel || (fill_ff != '0));
   assign fill_short = fill_ff <= FW'(width);
   assign w_last     = CW'(width - WW'(1));
   assign h_last     = RW'(height - HW'(1));

   // The result position trails the input by one row and one pixel, wrapping into the
   // previous frame near the start.
   assign borrow  = col_ff == '0;
   assign qc      = borrow ? w_last : col_ff - CW'(1);
   assign row_ext = (HW+1)'(row_ff);
   assign row_sub = borrow ? (HW+1)'(2) : (HW+1)'(1);
   assign qr_wide = (row_ext >= row_sub) ? row_ext - row_sub
                                         : row_ext + (HW+1)'(height) - row_sub;
   assign qr      = RW'(qr_wide);
   assign q_last  = (qc == w_last) && (qr == h_last);

   assign win_new = {pad, line[0], line[1], win_ff[8:3]};

   always_comb begin
      mask = bm33_pkg::WINDOW_FULL;
      if (qc == '0) begin
         mask = mask & ~bm33_pkg::MASK_LEFT_COL;
      end
      if (qc == w_last) begin
         mask = mask & ~bm33_pkg::MASK_RIGHT_COL;
      end
      if (qr == '0) begin
         mask = mask & ~bm33_pkg::MASK_TOP_ROW;
      end
      if (qr == h_last) begin
         mask = mask & ~bm33_pkg::MASK_BOTTOM_ROW;
      end
   end

   assign eff    = win_new & mask;
   assign result = ctrl.mode.dilate ? (|eff) : (&eff);

   assign col_next = (col_ff == w_last) ? '0 : col_ff + CW'(1);
   assign row_next = (col_ff != w_last) ? row_ff :
                     (row_ff == h_last) ? '0 : row_ff + RW'(1);

   always_comb begin
      tok_out = tok_in;
      keep    = 1'b1;
      if (advance) begin
         tok_out.is_pixel = 1'b1;
         tok_out.value    = result;
      end
      // The first row and a pixel of each frame only prime the window.
      if (ctrl.mode.active && tok_in.is_pixel && fill_short) begin
         keep = 1'b0;
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      fill_in = fill_ff;
      win_in  = win_ff;
      if (ctrl.restart) begin
         col_in  = '0;
         row_in  = '0;
         fill_in = '0;
         win_in  = '0;
      end else if (ctrl.process && advance) begin
         col_in = col_next;
         row_in = row_next;
         win_in = win_new;
         if (tok_in.is_pixel) begin
            if (fill_short) begin
               fill_in = fill_ff + FW'(1);
            end
         end else if (q_last) begin
            col_in  = '0;
            row_in  = '0;
            fill_in = '0;
         end else begin
            fill_in = fill_ff - FW'(1);
         end
      end
   end

   always_comb begin
      ram_we    = ctrl.clear || (ctrl.process && advance);
      ram_waddr = ctrl.clear ? clear_addr : col_ff;
      ram_wdata = ctrl.clear ? '0 : {line[0], pad};
   end

   assign fwd_hit_in = ram_we && (ram_waddr == col_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         fill_ff    <= '0;
         win_ff     <= '0;
         fwd_hit_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         fill_ff    <= fill_in;
         win_ff     <= win_in;
         fwd_hit_ff <= fwd_hit_in;
      end
      fwd_data_ff <= ram_wdata;
   end

endmodule
`default_nettype wire

[hw/rtl/binary_morphology_3x3_stream.sv]
// Transactions move through the token register of each pass, then the result register, at
// one per cycle unless stalled. Each pass reads and writes its line RAM once per pixel.
// The first image_width + 1 pixels of a frame in each active pass yield no result.
// Reset is synchronous; afterwards the line RAMs are cleared at all MAX_WIDTH addresses, during
// which req_stall stays high (register writes are still taken).
// Depends on bm33_pkg, bm33_pass and bm33_ram.
`default_nettype none
module binary_morphology_3x3_stream #(
   parameter int MAX_WIDTH   = bm33_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT  = bm33_pkg::MAX_HEIGHT_DEFAULT,
   parameter int PASS_STAGES = bm33_pkg::PASS_STAGES_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire bm33_pkg::req_type                       req_data,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output bm33_pkg::rsp_type                            rsp_data,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [bm33_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [bm33_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RESET_WIDTH  = (bm33_pkg::DEFAULT_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                       : bm33_pkg::DEFAULT_WIDTH;
   localparam int RESET_HEIGHT = (bm33_pkg::DEFAULT_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                                         : bm33_pkg::DEFAULT_HEIGHT;

   // Configuration
   bm33_pkg::mode_type mode_ff, mode_in;
   logic               size_ff, size_in;
   logic [WW-1:0]      width_ff, width_in;
   logic [HW-1:0]      height_ff, height_in;
   logic               restart;
   logic               csr_write;

   // Line RAM clearing after reset
   logic               clear_ff, clear_in;
   logic [CW-1:0]      clear_addr_ff, clear_addr_in;

   // Pass pipeline
   logic [PASS_STAGES-1:0] tv_ff, tv_in;
   bm33_pkg::token_type    tk_ff [PASS_STAGES];
   bm33_pkg::token_type    tk_in [PASS_STAGES];
   bm33_pkg::token_type    tok_out [PASS_STAGES];
   logic [PASS_STAGES-1:0] keep;
   logic [PASS_STAGES-1:0] move;
   logic [PASS_STAGES:0]   space;
   bm33_pkg::pass_ctrl_type pass_ctrl [PASS_STAGES];
   logic                   req_accept;

   // Result register and output raster position
   logic                   rsp_valid_ff, rsp_valid_in;
   bm33_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic [CW-1:0]          out_col_ff, out_col_in;
   logic [RW-1:0]          out_row_ff, out_row_in;
   logic                   out_load;
   logic                   out_last;
   logic                   out_col_end;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      mode_in   = mode_ff;
      size_in   = size_ff;
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_write) begin
         case (csr_index)
            bm33_pkg::CSR_OPERATION_MODE: begin
               mode_in = bm33_pkg::mode_type'(csr_data[1:0]);
               restart = 1'b1;
            end
            bm33_pkg::CSR_ELEMENT_SIZE: begin
               size_in = csr_data[0];
               restart = 1'b1;
            end
            bm33_pkg::CSR_IMAGE_WIDTH: begin
               if (int'(csr_data) < bm33_pkg::MIN_DIM) begin
                  width_in = WW'(bm33_pkg::MIN_DIM);
               end else if (int'(csr_data) > MAX_WIDTH) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(csr_data);
               end
               restart = 1'b1;
            end
            bm33_pkg::CSR_IMAGE_HEIGHT: begin
               if (int'(csr_data) < bm33_pkg::MIN_DIM) begin
                  height_in = HW'(bm33_pkg::MIN_DIM);
               end else if (int'(csr_data) > MAX_HEIGHT) begin
                  height_in = HW'(MAX_HEIGHT);
               end else begin
                  height_in = HW'(csr_data);
               end
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + CW'(1);
         if (clear_addr_ff == CW'(MAX_WIDTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   // A stage moves on when the slot after it is free or is itself moving on.
   always_comb begin
      space[PASS_STAGES] = !rsp_valid_ff || !rsp_stall;
      for (int s = PASS_STAGES - 1; s >= 0; s--) begin
         move[s]  = tv_ff[s] && space[s+1];
         space[s] = !tv_ff[s] || move[s];
      end
   end

   assign req_stall  = clear_ff || !space[0];
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      for (int s = 0; s < PASS_STAGES; s++) begin
         pass_ctrl[s].mode    = bm33_pkg::pass_mode(mode_ff, size_ff, s, PASS_STAGES);
         pass_ctrl[s].process = move[s];
         pass_ctrl[s].restart = restart;
         pass_ctrl[s].clear   = clear_ff;
      end
   end

   for (genvar g = 0; g < PASS_STAGES; g++) begin : g_pass
      bm33_pass #(
         .MAX_WIDTH  (MAX_WIDTH),
         .MAX_HEIGHT (MAX_HEIGHT)
      ) u_pass (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (pass_ctrl[g]),
         .width      (width_ff),
         .height     (height_ff),
         .clear_addr (clear_addr_ff),
         .tok_in     (tk_ff[g]),
         .tok_out    (tok_out[g]),
         .keep       (keep[g])
      );
   end

   always_comb begin
      tv_in[0] = req_accept ? 1'b1 : (move[0] ? 1'b0 : tv_ff[0]);
      tk_in[0] = tk_ff[0];
      if (req_accept) begin
         tk_in[0].is_pixel = req_data.action == bm33_pkg::ACTION_PUSH;
         tk_in[0].value    = req_data.pixel_in;
      end
      for (int s = 1; s < PASS_STAGES; s++) begin
         tv_in[s] = move[s-1] ? keep[s-1] : (move[s] ? 1'b0 : tv_ff[s]);
         tk_in[s] = move[s-1] ? tok_out[s-1] : tk_ff[s];
      end
   end

   // A drain step that no pass could use leaves the last stage without a result.
   assign out_load = move[PASS_STAGES-1] && keep[PASS_STAGES-1]
                     && tok_out[PASS_STAGES-1].is_pixel;

   assign out_col_end = out_col_ff == CW'(width_ff - WW'(1));
   assign out_last    = out_col_end && (out_row_ff == RW'(height_ff - HW'(1)));

   always_comb begin
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      if (out_load) begin
         rsp_data_in.pixel_out  = tok_out[PASS_STAGES-1].value;
         rsp_data_in.frame_last = out_last;
         if (out_col_end) begin
            out_col_in = '0;
            out_row_in = out_last ? '0 : out_row_ff + RW'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end
      if (restart) begin
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= bm33_pkg::MODE_ERODE;
         size_ff       <= 1'b0;
         width_ff      <= WW'(RESET_WIDTH);
         height_ff     <= HW'(RESET_HEIGHT);
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         tv_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
      end else begin
         mode_ff       <= mode_in;
         size_ff       <= size_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         tv_ff         <= tv_in;
         rsp_valid_ff  <= rsp_valid_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
      end
      rsp_data_ff <= rsp_data_in;
      for (int s = 0; s < PASS_STAGES; s++) begin
         tk_ff[s] <= tk_in[s];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (tv_ff == '0) && !rsp_valid_ff)
      else $error("pipeline holds a transaction while the line RAMs are being cleared");

   a_first_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (tv_ff[0] && !move[0]) |=> tv_ff[0] && $stable(tk_ff[0]))
      else $error("a waiting transaction in the first pass was lost or altered");

   a_out_position: assert property (@(posedge clock) disable iff (reset)
      (WW'(out_col_ff) < width_ff) && (HW'(out_row_ff) < height_ff))
      else $error("output raster position lies outside the frame");
`endif

endmodule
`default_nettype wire
